// ----- design/box_filter_image_downscaler_core_assert.svh -----
// Assertion macros of the box filter downscaler modules.
// No dependencies; pulled in with `include by the modules that check themselves.
`ifndef BOX_FILTER_IMAGE_DOWNSCALER_CORE_ASSERT_SVH
`define BOX_FILTER_IMAGE_DOWNSCALER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define BFID_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("box filter downscaler: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define BFID_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("box filter downscaler: next-cycle check failed");

`endif

// ----- design/bfid_pkg.sv -----
// Shared types and constants of the box filter image downscaler.
// No dependencies; used by the interfaces, the controller, the datapath and the top level.
package bfid_pkg;

   localparam int PIX_W     = 8;
   localparam int CFG_W     = 11;
   localparam int FACTOR_W  = 5;
   localparam int ROW_LIMIT = 1024;
   localparam int ROW_W     = 10;
   localparam int CSR_IDX_W = 2;
   localparam int NUM_CHAN  = 3;

   // Register indexes on the CSR port
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_ROWS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_COLS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_FACTOR = 2'd2;

   // Register reset values
   localparam logic [CFG_W-1:0]    ROWS_RESET   = 11'd1024;
   localparam logic [CFG_W-1:0]    COLS_RESET   = 11'd1024;
   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 5'd2;

   // Iteration counts of the remainder check and the averaging divider
   localparam int CHK_STEPS = CFG_W;
   localparam int DIV_STEPS = PIX_W;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic chk_load;
      logic chk_step;
      logic chk_flag;
      logic pix_read;
      logic acc_write;
      logic div_load;
      logic div_step;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic chk_last;
      logic div_last;
      logic bad;
      logic block_end;
      logic out_busy;
   } status_type;

endpackage

// ----- design/bfid_stream_if.sv -----
// Valid/ready stream interfaces for pixel requests and averaged results.
// Depends on bfid_pkg for the field widths.
interface bfid_req_if;
   logic                       valid;
   logic                       ready;
   logic [bfid_pkg::PIX_W-1:0] chan_zero;
   logic [bfid_pkg::PIX_W-1:0] chan_one;
   logic [bfid_pkg::PIX_W-1:0] chan_two;

   modport source (output valid, output chan_zero, output chan_one, output chan_two,
                   input ready);
   modport sink   (input valid, input chan_zero, input chan_one, input chan_two,
                   output ready);
endinterface

interface bfid_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bfid_pkg::PIX_W-1:0] avg_zero;
   logic [bfid_pkg::PIX_W-1:0] avg_one;
   logic [bfid_pkg::PIX_W-1:0] avg_two;
   logic                       frame_done;
   logic                       bad_config;

   modport source (output valid, output avg_zero, output avg_one, output avg_two,
                   output frame_done, output bad_config, input ready);
   modport sink   (input valid, input avg_zero, input avg_one, input avg_two,
                   input frame_done, input bad_config, output ready);
endinterface

// ----- design/box_filter_image_downscaler_core.sv -----
// Box filter downscaler: takes an RGB-style 8-bit image in raster order and returns one
// floor-averaged pixel per factor x factor block, with frame_done on the last one. Each
// pixel is captured on request and then added in by a read-modify-write of the column-sum
// memory; a block-closing pixel then runs the 8-step restoring divider that divides the
// three sums by the block area, and waits for any previous result to be taken. After reset
// and after every register write the block runs a configuration check (an 11-step
// remainder loop) with req ready low. With an unusable configuration every request is
// dropped and answered by one bad_config result.
// Depends on bfid_pkg, bfid_stream_if, bfid_ctrl and bfid_datapath.
module box_filter_image_downscaler_core #(
   parameter int MAX_COLS   = 1024,
   parameter int MAX_FACTOR = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   bfid_req_if.sink                       req_bus,
   bfid_rsp_if.source                     rsp_bus,
   input  logic                           csr_we,
   input  logic [bfid_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bfid_pkg::CFG_W-1:0]     csr_wdata
);

   bfid_pkg::cmd_type    cmd;
   bfid_pkg::status_type status;
   logic                 csr_hit;

   // Only writes to a defined register count; others are ignored
   assign csr_hit = csr_we && ((csr_index == bfid_pkg::REG_IMAGE_ROWS) ||
                               (csr_index == bfid_pkg::REG_IMAGE_COLS) ||
                               (csr_index == bfid_pkg::REG_SCALE_FACTOR));

   bfid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .csr_hit   (csr_hit),
      .status    (status),
      .cmd       (cmd)
   );

   bfid_datapath #(
      .MAX_COLS   (MAX_COLS),
      .MAX_FACTOR (MAX_FACTOR)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_hit    (csr_hit),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .chan_zero  (req_bus.chan_zero),
      .chan_one   (req_bus.chan_one),
      .chan_two   (req_bus.chan_two),
      .cmd        (cmd),
      .status     (status),
      .rsp_ready  (rsp_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .avg_zero   (rsp_bus.avg_zero),
      .avg_one    (rsp_bus.avg_one),
      .avg_two    (rsp_bus.avg_two),
      .frame_done (rsp_bus.frame_done),
      .bad_config (rsp_bus.bad_config)
   );

endmodule

// ----- design/bfid_ctrl.sv -----
// Controller state machine of the box filter downscaler.
// Depends on bfid_pkg (command/status structs) and the assertion macro header.
`include "box_filter_image_downscaler_core_assert.svh"

module bfid_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 csr_hit,
   input  bfid_pkg::status_type status,
   output bfid_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_LOAD  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_FLAG  = 3'd2;
   localparam logic [2:0] S_IDLE  = 3'd3;
   localparam logic [2:0] S_ACC   = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_EMIT  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       req_accept;

   // Take a request only when idle and no register write lands this cycle
   assign req_ready  = (state_ff == S_IDLE) && !csr_hit;
   assign req_accept = req_valid && req_ready;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      if (csr_hit) begin
         state_in = S_LOAD;
      end else begin
         case (state_ff)
            S_LOAD: begin
               cmd.chk_load = 1'b1;
               state_in     = S_CHECK;
            end
            S_CHECK: begin
               cmd.chk_step = 1'b1;
               if (status.chk_last) begin
                  state_in = S_FLAG;
               end
            end
            S_FLAG: begin
               cmd.chk_flag = 1'b1;
               state_in     = S_IDLE;
            end
            S_IDLE: begin
               if (req_accept) begin
                  cmd.pix_read = 1'b1;
                  state_in     = status.bad ? S_EMIT : S_ACC;
               end
            end
            S_ACC: begin
               cmd.acc_write = 1'b1;
               if (status.block_end) begin
                  cmd.div_load = 1'b1;
                  state_in     = S_DIV;
               end else begin
                  state_in = S_IDLE;
               end
            end
            S_DIV: begin
               cmd.div_step = 1'b1;
               if (status.div_last) begin
                  state_in = S_EMIT;
               end
            end
            S_EMIT: begin
               if (!status.out_busy) begin
                  cmd.out_load = 1'b1;
                  state_in     = S_IDLE;
               end
            end
            default: begin
               state_in = S_LOAD;
            end
         endcase
      end
   end

   // Hold state; restart the configuration check after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   `BFID_ASSERT_NEXT(a_good_req_accumulates, clock, reset, req_accept && !status.bad, state_ff == S_ACC)
   `BFID_ASSERT_IMPLY(a_no_result_overwrite, clock, reset, cmd.out_load, !status.out_busy)
   `BFID_ASSERT_NEXT(a_divide_then_emit, clock, reset, (state_ff == S_DIV) && status.div_last && !csr_hit, state_ff == S_EMIT)

endmodule

// ----- design/bfid_datapath.sv -----
// Datapath of the box filter downscaler: registers, position counters, column-sum
// memory, remainder check and averaging divider. Depends on bfid_pkg.
module bfid_datapath #(
   parameter int MAX_COLS   = 1024,
   parameter int MAX_FACTOR = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_hit,
   input  logic [bfid_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bfid_pkg::CFG_W-1:0]     csr_wdata,
   input  logic [bfid_pkg::PIX_W-1:0]     chan_zero,
   input  logic [bfid_pkg::PIX_W-1:0]     chan_one,
   input  logic [bfid_pkg::PIX_W-1:0]     chan_two,
   input  bfid_pkg::cmd_type              cmd,
   output bfid_pkg::status_type           status,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [bfid_pkg::PIX_W-1:0]     avg_zero,
   output logic [bfid_pkg::PIX_W-1:0]     avg_one,
   output logic [bfid_pkg::PIX_W-1:0]     avg_two,
   output logic                           frame_done,
   output logic                           bad_config
);

   localparam int PIX_W    = bfid_pkg::PIX_W;
   localparam int CFG_W    = bfid_pkg::CFG_W;
   localparam int FACTOR_W = bfid_pkg::FACTOR_W;
   localparam int ROW_W    = bfid_pkg::ROW_W;
   localparam int NCH      = bfid_pkg::NUM_CHAN;
   localparam int CW       = $clog2(MAX_COLS);
   localparam int IW       = $clog2(MAX_FACTOR);
   localparam int XW       = IW + FACTOR_W;
   localparam int CMP_W    = (CW >= CFG_W) ? CW + 1 : CFG_W + 1;
   localparam int AW       = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
   localparam int SW       = $clog2(255 * MAX_FACTOR * MAX_FACTOR + 1);
   localparam int DW       = AW + PIX_W;
   localparam int MW       = CFG_W + FACTOR_W;
   localparam int CHK_CW   = $clog2(bfid_pkg::CHK_STEPS);
   localparam int DIV_CW   = $clog2(bfid_pkg::DIV_STEPS);

   // Configuration registers
   logic [CFG_W-1:0]    image_rows_ff;
   logic [CFG_W-1:0]    image_cols_ff;
   logic [FACTOR_W-1:0] scale_factor_ff;

   // Position of the next pixel
   logic [ROW_W-1:0] row_ff;
   logic [CW-1:0]    col_ff;
   logic [IW-1:0]    rin_ff;
   logic [IW-1:0]    cin_ff;
   logic [CW-1:0]    slot_ff;

   // Configuration check
   logic [MW-1:0]           rrem_ff;
   logic [MW-1:0]           crem_ff;
   logic [CHK_CW-1:0]       chk_cnt_ff;
   logic                    bad_ff;
   logic [AW-1:0]           area_ff;
   logic [MW-1:0]           chk_trial;
   logic [CHK_CW-1:0]       chk_shift;
   logic                    range_bad;
   logic [2*FACTOR_W-1:0]   factor_sq;

   // Accumulation
   logic [PIX_W-1:0]  pix_ff    [NCH];
   logic [NCH*SW-1:0] column_sums_mem [MAX_COLS];
   logic [NCH*SW-1:0] rdata_ff;
   logic [NCH*SW-1:0] sum_word;
   logic              frame_ff;

   // Divider
   logic [DW-1:0]     rem_ff  [NCH];
   logic [PIX_W-1:0]  quot_ff [NCH];
   logic [DIV_CW-1:0] div_cnt_ff;
   logic [DIV_CW-1:0] div_shift;
   logic [DW-1:0]     div_trial;

   // Output register
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] avg_ff [NCH];
   logic             frame_out_ff;
   logic             bad_out_ff;

   // Position decode
   logic [XW-1:0] factor_m1;
   logic          rin_end;
   logic          cin_end;
   logic          first_px;
   logic          last_row;
   logic          last_col;

   assign factor_m1 = XW'(scale_factor_ff) - XW'(1);
   assign rin_end   = (XW'(rin_ff) == factor_m1);
   assign cin_end   = (XW'(cin_ff) == factor_m1);
   assign first_px  = (rin_ff == '0) && (cin_ff == '0);
   assign last_row  = (CFG_W'(row_ff) + CFG_W'(1)) >= image_rows_ff;
   assign last_col  = (CMP_W'(col_ff) + CMP_W'(1)) >= CMP_W'(image_cols_ff);

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_rows_ff   <= bfid_pkg::ROWS_RESET;
         image_cols_ff   <= bfid_pkg::COLS_RESET;
         scale_factor_ff <= bfid_pkg::FACTOR_RESET;
      end else if (csr_hit) begin
         case (csr_index)
            bfid_pkg::REG_IMAGE_ROWS:   image_rows_ff   <= csr_wdata;
            bfid_pkg::REG_IMAGE_COLS:   image_cols_ff   <= csr_wdata;
            bfid_pkg::REG_SCALE_FACTOR: scale_factor_ff <= csr_wdata[FACTOR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Advance the raster position; restart the frame on a register write
   always_ff @(posedge clock) begin
      if (reset || csr_hit) begin
         row_ff  <= '0;
         col_ff  <= '0;
         rin_ff  <= '0;
         cin_ff  <= '0;
         slot_ff <= '0;
      end else if (cmd.acc_write) begin
         if (last_col) begin
            col_ff  <= '0;
            cin_ff  <= '0;
            slot_ff <= '0;
            if (last_row) begin
               row_ff <= '0;
               rin_ff <= '0;
            end else begin
               row_ff <= row_ff + ROW_W'(1);
               rin_ff <= rin_end ? '0 : rin_ff + IW'(1);
            end
         end else begin
            col_ff <= col_ff + CW'(1);
            if (cin_end) begin
               cin_ff  <= '0;
               slot_ff <= slot_ff + CW'(1);
            end else begin
               cin_ff <= cin_ff + IW'(1);
            end
         end
      end
   end

   // Range limits of the configuration
   assign range_bad = (image_rows_ff == '0) || (image_cols_ff == '0) ||
                      (scale_factor_ff == '0) ||
                      (32'(image_rows_ff) > 32'(bfid_pkg::ROW_LIMIT)) ||
                      (32'(image_cols_ff) > 32'(MAX_COLS)) ||
                      (32'(scale_factor_ff) > 32'(MAX_FACTOR));
   assign factor_sq = (2*FACTOR_W)'(scale_factor_ff) * (2*FACTOR_W)'(scale_factor_ff);
   assign chk_shift = CHK_CW'(bfid_pkg::CHK_STEPS - 1) - chk_cnt_ff;
   assign chk_trial = MW'(scale_factor_ff) << chk_shift;

   // Reduce rows and columns modulo the factor, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (cmd.chk_load) begin
         rrem_ff    <= MW'(image_rows_ff);
         crem_ff    <= MW'(image_cols_ff);
         chk_cnt_ff <= '0;
      end else if (cmd.chk_step) begin
         if (rrem_ff >= chk_trial) begin
            rrem_ff <= rrem_ff - chk_trial;
         end
         if (crem_ff >= chk_trial) begin
            crem_ff <= crem_ff - chk_trial;
         end
         chk_cnt_ff <= chk_cnt_ff + CHK_CW'(1);
      end
      if (cmd.chk_flag) begin
         bad_ff  <= range_bad || (rrem_ff != '0) || (crem_ff != '0);
         area_ff <= AW'(factor_sq);
      end
   end

   // Start a block or add to its running sums
   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         sum_word[c*SW +: SW] = first_px ? SW'(pix_ff[c])
                                         : rdata_ff[c*SW +: SW] + SW'(pix_ff[c]);
      end
   end

   // Capture the request and read its column slot
   always_ff @(posedge clock) begin
      if (cmd.pix_read) begin
         pix_ff[0] <= chan_zero;
         pix_ff[1] <= chan_one;
         pix_ff[2] <= chan_two;
         rdata_ff  <= column_sums_mem[slot_ff];
      end
      if (cmd.acc_write) begin
         column_sums_mem[slot_ff] <= sum_word;
      end
      if (cmd.div_load) begin
         frame_ff <= last_row && last_col;
      end
   end

   // Restoring divide of each sum by the block area
   assign div_shift = DIV_CW'(bfid_pkg::DIV_STEPS - 1) - div_cnt_ff;
   assign div_trial = DW'(area_ff) << div_shift;

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         for (int c = 0; c < NCH; c++) begin
            rem_ff[c]  <= DW'(sum_word[c*SW +: SW]);
            quot_ff[c] <= '0;
         end
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         for (int c = 0; c < NCH; c++) begin
            if (rem_ff[c] >= div_trial) begin
               rem_ff[c]  <= rem_ff[c] - div_trial;
               quot_ff[c] <= {quot_ff[c][PIX_W-2:0], 1'b1};
            end else begin
               quot_ff[c] <= {quot_ff[c][PIX_W-2:0], 1'b0};
            end
         end
         div_cnt_ff <= div_cnt_ff + DIV_CW'(1);
      end
   end

   // Load the result register; drop valid once the result is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         for (int c = 0; c < NCH; c++) begin
            avg_ff[c] <= bad_ff ? '0 : quot_ff[c];
         end
         frame_out_ff <= !bad_ff && frame_ff;
         bad_out_ff   <= bad_ff;
      end
   end

   assign status.chk_last  = (chk_cnt_ff == CHK_CW'(bfid_pkg::CHK_STEPS - 1));
   assign status.div_last  = (div_cnt_ff == DIV_CW'(bfid_pkg::DIV_STEPS - 1));
   assign status.bad       = bad_ff;
   assign status.block_end = rin_end && cin_end;
   assign status.out_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign avg_zero   = avg_ff[0];
   assign avg_one    = avg_ff[1];
   assign avg_two    = avg_ff[2];
   assign frame_done = frame_out_ff;
   assign bad_config = bad_out_ff;

endmodule
